@@ src/nearest_neighbor_scaler_swizzle_defines.svh @@
// ---------------------------------------------------------------------------
// nearest_neighbor_scaler_swizzle_defines
// assertion macros shared by the scaler rtl
// ---------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_SCALER_SWIZZLE_DEFINES_SVH
`define NEAREST_NEIGHBOR_SCALER_SWIZZLE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define NNS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define NNS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define NNS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define NNS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ src/nns_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nns_pkg
// shared types and constants of the nearest-neighbor scaler
// ---------------------------------------------------------------------------
package nns_pkg;

	localparam int MAX_SIDE_DEF = 64;
	localparam int CFG_W        = 7;
	localparam int COORD_W      = 6;
	localparam int CHAN_W       = 8;
	localparam int PIX_W        = 4 * CHAN_W;
	localparam int IN_DATA_W    = 48;
	localparam int OUT_DATA_W   = PIX_W;
	localparam int APB_DATA_W   = 32;
	localparam int APB_ADDR_W   = 4;
	localparam int Q_DEPTH      = 2;

	// request kind carried in s_tuser
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_FETCH = 1'b1;

	// register indexes
	localparam logic [1:0] REG_SRC_WIDTH = 2'd0;
	localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [1:0] REG_TGT_WIDTH = 2'd2;
	localparam logic [1:0] REG_TGT_HEIGHT = 2'd3;

	// classified request handed from front to back
	typedef struct packed {
		logic               kind;
		logic               oor;
		logic [PIX_W-1:0]   pix;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} op_t;

endpackage

@@ src/nearest_neighbor_scaler_swizzle.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nearest_neighbor_scaler_swizzle
// nearest-neighbor image scaler returning pixels in bgra order
// ---------------------------------------------------------------------------
// Requests enter on the s_ stream: s_tuser = 0 loads the next source pixel
// (rgba in s_tdata) at the running write position, s_tuser = 1 fetches the
// output pixel at (out_col, out_row). Each fetch gives one result on the m_
// stream, bgra in m_tdata and the out_of_range flag in m_tuser; loads give
// none. Sizes are set over the apb port; the user must do so only while
// the block is idle, as the block itself does not enforce it. A load is
// written to the store as the back end takes it. A fetch runs through the
// one shared restoring divider that does the column then the row, N
// quotient bits each, N = 6 + clog2(MAX_SIDE + 1), one bit per cycle,
// then the index multiply and the registered store read. A fetch outside
// the output size skips the divides. The front queue registers requests
// and holds two of them, so requests are still taken while a result waits
// on a stalled receiver; the back end stops only when it has a new result
// and the output register is full. Reset clears the write position, the
// queue and the output valid and restores the size registers; the pixel
// store is not cleared and must be loaded before it is fetched.
// ---------------------------------------------------------------------------
`include "nearest_neighbor_scaler_swizzle_defines.svh"

module nearest_neighbor_scaler_swizzle #(
	parameter int MAX_SIDE = nns_pkg::MAX_SIDE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// in_red, in_green, in_blue, in_alpha, out_col, out_row, zero fill
	input  logic [nns_pkg::IN_DATA_W-1:0]  s_tdata,
	// action
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// res_blue, res_green, res_red, res_alpha
	output logic [nns_pkg::OUT_DATA_W-1:0] m_tdata,
	// out_of_range
	output logic                           m_tuser,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [nns_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [nns_pkg::APB_DATA_W-1:0] pwdata,
	output logic [nns_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);

	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int CFG_W  = nns_pkg::CFG_W;
	localparam int CMP_W  = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;

	logic [CFG_W-1:0] src_w_q;
	logic [CFG_W-1:0] src_h_q;
	logic [CFG_W-1:0] tgt_w_q;
	logic [CFG_W-1:0] tgt_h_q;

	logic [1:0]        reg_idx;
	logic              cfg_wr;
	logic [SIDE_W-1:0] sw;
	logic [SIDE_W-1:0] sh;
	logic [SIDE_W-1:0] tw;
	logic [SIDE_W-1:0] th;
	logic [SIDE_W-1:0] dw;
	logic [SIDE_W-1:0] dh;
	logic              resize;

	logic         q_valid;
	logic         q_ready;
	nns_pkg::op_t q_head;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= CFG_W'(64);
			src_h_q <= CFG_W'(64);
			tgt_w_q <= '0;
			tgt_h_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				nns_pkg::REG_SRC_WIDTH:  src_w_q <= pwdata[CFG_W-1:0];
				nns_pkg::REG_SRC_HEIGHT: src_h_q <= pwdata[CFG_W-1:0];
				nns_pkg::REG_TGT_WIDTH:  tgt_w_q <= pwdata[CFG_W-1:0];
				nns_pkg::REG_TGT_HEIGHT: tgt_h_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			nns_pkg::REG_SRC_WIDTH:  prdata = nns_pkg::APB_DATA_W'(src_w_q);
			nns_pkg::REG_SRC_HEIGHT: prdata = nns_pkg::APB_DATA_W'(src_h_q);
			nns_pkg::REG_TGT_WIDTH:  prdata = nns_pkg::APB_DATA_W'(tgt_w_q);
			nns_pkg::REG_TGT_HEIGHT: prdata = nns_pkg::APB_DATA_W'(tgt_h_q);
			default:                 prdata = '0;
		endcase
	end

	// source sizes clamp to 1..MAX_SIDE, targets to 0..MAX_SIDE
	always_comb begin
		if (src_w_q == '0) begin
			sw = SIDE_W'(1);
		end else if (CMP_W'(src_w_q) > CMP_W'(MAX_SIDE)) begin
			sw = SIDE_W'(MAX_SIDE);
		end else begin
			sw = SIDE_W'(src_w_q);
		end
		if (src_h_q == '0) begin
			sh = SIDE_W'(1);
		end else if (CMP_W'(src_h_q) > CMP_W'(MAX_SIDE)) begin
			sh = SIDE_W'(MAX_SIDE);
		end else begin
			sh = SIDE_W'(src_h_q);
		end
		tw = (CMP_W'(tgt_w_q) > CMP_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : SIDE_W'(tgt_w_q);
		th = (CMP_W'(tgt_h_q) > CMP_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : SIDE_W'(tgt_h_q);
		resize = (tw != '0) && (th != '0);
		dw = resize ? tw : sw;
		dh = resize ? th : sh;
	end

	nns_front #(
		.SIDE_W (SIDE_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.dw       (dw),
		.dh       (dh),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_head   (q_head)
	);

	nns_back #(
		.MAX_SIDE (MAX_SIDE),
		.SIDE_W   (SIDE_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.sw       (sw),
		.sh       (sh),
		.dw       (dw),
		.dh       (dh),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_head   (q_head),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// an out-of-range result carries a zero pixel
	`NNS_ASSERT_IMP(a_oor_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == '0, "oor pixel not zero")
	// a stalled input side means the queue holds requests
	`NNS_ASSERT_IMP(a_full_has_head, clk, arst_n, !s_tready, q_valid, "queue full but empty")
	// once a fetch is taken the back end is busy with it
	`NNS_ASSERT_NXT(a_fetch_busy, clk, arst_n, q_valid && q_ready && (q_head.kind == nns_pkg::ACT_FETCH), !q_ready, "back end idle after fetch")

endmodule

@@ src/nns_div.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nns_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module nns_div #(
	parameter int N   = 13,
	parameter int D_W = 7
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N-1:0]   dividend,
	input  logic [D_W-1:0] divisor,
	output logic           done,
	output logic [N-1:0]   quotient
);

	localparam int CNT_W = $clog2(N + 1);

	logic [D_W:0]   rem_q;
	logic [N-1:0]   quo_q;
	logic [D_W-1:0] div_q;
	logic [CNT_W-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;

	logic [D_W:0] trial;
	logic [D_W:0] diff;
	logic         ge;

	always_comb begin
		trial = {rem_q[D_W-1:0], quo_q[N-1]};
		ge    = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(N);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// dividend bits shift out of the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff : trial;
			quo_q <= {quo_q[N-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ src/nns_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nns_front
// accepts requests, classifies them and queues them for the back end
// ---------------------------------------------------------------------------
module nns_front #(
	parameter int SIDE_W = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// red, green, blue, alpha, out_col, out_row, zero fill
	input  logic [nns_pkg::IN_DATA_W-1:0] s_tdata,
	// action
	input  logic                          s_tuser,
	input  logic [SIDE_W-1:0]             dw,
	input  logic [SIDE_W-1:0]             dh,
	output logic                          q_valid,
	input  logic                          q_ready,
	output nns_pkg::op_t                  q_head
);

	localparam int DEPTH = nns_pkg::Q_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam int CW = (SIDE_W > nns_pkg::COORD_W) ? SIDE_W : nns_pkg::COORD_W;

	nns_pkg::op_t       entries_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [FILL_W-1:0]  fill_q;

	nns_pkg::op_t op;
	logic         push;
	logic         pop;

	always_comb begin
		op.kind = s_tuser;
		op.pix  = s_tdata[nns_pkg::PIX_W-1:0];
		op.col  = s_tdata[nns_pkg::PIX_W +: nns_pkg::COORD_W];
		op.row  = s_tdata[nns_pkg::PIX_W + nns_pkg::COORD_W +: nns_pkg::COORD_W];
		// a fetch outside the output size gets no store read
		op.oor  = (s_tuser == nns_pkg::ACT_FETCH) &&
			((CW'(op.col) >= CW'(dw)) || (CW'(op.row) >= CW'(dh)));
	end

	assign s_tready = fill_q != FILL_W'(DEPTH);
	assign q_valid  = fill_q != '0;
	assign q_head   = entries_q[rd_ptr_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= op;
		end
	end

endmodule

@@ src/nns_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nns_back
// executes loads and fetches against the pixel store
// ---------------------------------------------------------------------------
module nns_back #(
	parameter int MAX_SIDE = nns_pkg::MAX_SIDE_DEF,
	parameter int SIDE_W   = $clog2(MAX_SIDE + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [SIDE_W-1:0]              sw,
	input  logic [SIDE_W-1:0]              sh,
	input  logic [SIDE_W-1:0]              dw,
	input  logic [SIDE_W-1:0]              dh,
	input  logic                           q_valid,
	output logic                           q_ready,
	input  nns_pkg::op_t                   q_head,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// res_blue, res_green, res_red, res_alpha
	output logic [nns_pkg::OUT_DATA_W-1:0] m_tdata,
	// out_of_range
	output logic                           m_tuser
);

	localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = 2 * SIDE_W;
	localparam int DIV_N  = nns_pkg::COORD_W + SIDE_W;
	localparam int CH     = nns_pkg::CHAN_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_STARTX = 3'd1;
	localparam logic [2:0] ST_DIVX   = 3'd2;
	localparam logic [2:0] ST_DIVY   = 3'd3;
	localparam logic [2:0] ST_ADDR   = 3'd4;
	localparam logic [2:0] ST_READ   = 3'd5;
	localparam logic [2:0] ST_OUT    = 3'd6;

	logic [nns_pkg::PIX_W-1:0] mem [DEPTH];

	logic [2:0]                    state_q;
	logic [ADDR_W-1:0]             wp_q;
	logic [nns_pkg::COORD_W-1:0]   col_q;
	logic [nns_pkg::COORD_W-1:0]   row_q;
	logic                          oor_q;
	logic [SIDE_W-1:0]             sx_q;
	logic [SIDE_W-1:0]             sy_q;
	logic [ADDR_W-1:0]             addr_q;
	logic [nns_pkg::PIX_W-1:0]     rd_q;
	logic                          res_valid_q;
	logic [nns_pkg::OUT_DATA_W-1:0] res_data_q;
	logic                          res_oor_q;

	logic [CNT_W-1:0]  count;
	logic [ADDR_W-1:0] wr_pos;
	logic [CNT_W-1:0]  wr_next;
	logic [ADDR_W-1:0] wp_d;
	logic              do_load;
	logic [CNT_W-1:0]  idx;
	logic              can_put;

	logic              div_start;
	logic [DIV_N-1:0]  div_dividend;
	logic [SIDE_W-1:0] div_divisor;
	logic              div_done;
	logic [DIV_N-1:0]  div_quotient;

	assign q_ready = state_q == ST_IDLE;
	assign do_load = q_valid && q_ready && (q_head.kind == nns_pkg::ACT_LOAD);
	assign can_put = !res_valid_q || m_tready;

	// write position wraps after the last source pixel; a stale one restarts at zero
	always_comb begin
		count   = CNT_W'(sw) * CNT_W'(sh);
		wr_pos  = (CNT_W'(wp_q) >= count) ? '0 : wp_q;
		wr_next = CNT_W'(wr_pos) + 1'b1;
		wp_d    = (wr_next >= count) ? '0 : ADDR_W'(wr_next);
		idx     = CNT_W'(sy_q) * CNT_W'(sw) + CNT_W'(sx_q);
	end

	// the x divide starts from its own state, the y divide as soon as x is done
	always_comb begin
		div_start = (state_q == ST_STARTX) || ((state_q == ST_DIVX) && div_done);
		if (state_q == ST_DIVX) begin
			div_dividend = DIV_N'(row_q) * DIV_N'(sh);
			div_divisor  = dh;
		end else begin
			div_dividend = DIV_N'(col_q) * DIV_N'(sw);
			div_divisor  = dw;
		end
	end

	nns_div #(
		.N   (DIV_N),
		.D_W (SIDE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (do_load) begin
				wp_q <= wp_d;
			end
			// a new result may refill the output register in the cycle it drains
			if ((state_q == ST_OUT) && can_put) begin
				res_valid_q <= 1'b1;
			end else if (m_tready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid && (q_head.kind == nns_pkg::ACT_FETCH)) begin
						state_q <= q_head.oor ? ST_OUT : ST_STARTX;
					end
				end
				ST_STARTX: state_q <= ST_DIVX;
				ST_DIVX: begin
					if (div_done) begin
						state_q <= ST_DIVY;
					end
				end
				ST_DIVY: begin
					if (div_done) begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: state_q <= ST_READ;
				ST_READ: state_q <= ST_OUT;
				ST_OUT: begin
					if (can_put) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) begin
			col_q <= q_head.col;
			row_q <= q_head.row;
			oor_q <= q_head.oor;
		end
		if ((state_q == ST_DIVX) && div_done) begin
			sx_q <= SIDE_W'(div_quotient);
		end
		if ((state_q == ST_DIVY) && div_done) begin
			sy_q <= SIDE_W'(div_quotient);
		end
		if (state_q == ST_ADDR) begin
			addr_q <= ADDR_W'(idx);
		end
		if ((state_q == ST_OUT) && can_put) begin
			res_oor_q <= oor_q;
			// store word is rgba from the low byte up, result is bgra
			res_data_q <= oor_q ? '0 :
				{rd_q[3*CH +: CH], rd_q[0 +: CH], rd_q[CH +: CH], rd_q[2*CH +: CH]};
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			mem[wr_pos] <= q_head.pix;
		end
		rd_q <= mem[addr_q];
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = res_data_q;
	assign m_tuser  = res_oor_q;

endmodule

@@ dv/tb_nearest_neighbor_scaler_swizzle.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_nearest_neighbor_scaler_swizzle
// self-checking bench for the nearest-neighbor scaler with bgra output
// ---------------------------------------------------------------------------
// Loads source images over the request stream and fetches scaled output
// pixels. A scoreboard tracks the pixel store, the write position and the
// size registers, and each fetch result is compared field by field in order.
// A short table of hand-picked requests and size settings runs first, then
// randomized phases with different source and target sizes and with the
// sender and receiver stalling at different rates. Fetches only ever touch
// store entries that were loaded since reset.
// ---------------------------------------------------------------------------
module tb_nearest_neighbor_scaler_swizzle;

	localparam int MAX_SIDE     = nns_pkg::MAX_SIDE_DEF;
	localparam int CHAN_W       = nns_pkg::CHAN_W;
	localparam int COORD_W      = nns_pkg::COORD_W;
	localparam int CFG_W        = nns_pkg::CFG_W;
	localparam int PIX_W        = nns_pkg::PIX_W;
	localparam int IN_DATA_W    = nns_pkg::IN_DATA_W;
	localparam int OUT_DATA_W   = nns_pkg::OUT_DATA_W;
	localparam int APB_DATA_W   = nns_pkg::APB_DATA_W;
	localparam int APB_ADDR_W   = nns_pkg::APB_ADDR_W;
	localparam int STORE_DEPTH  = MAX_SIDE * MAX_SIDE;
	localparam int DRAIN_CYCLES = 50;
	localparam int BURST_MAX    = 64;
	localparam int PRINT_MAX    = 100;

	typedef struct packed {
		logic               action;
		logic [CHAN_W-1:0]  red;
		logic [CHAN_W-1:0]  green;
		logic [CHAN_W-1:0]  blue;
		logic [CHAN_W-1:0]  alpha;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} request_t;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] alpha;
		logic              oor;
	} pixel_result_t;

	typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

	// first the sender idles lightly against a slow receiver, then swapped, then no idling
	typedef enum logic [1:0] {SLOW_SINK, SLOW_SRC, NO_IDLE} idle_mode_t;

	typedef struct {
		row_kind_t          kind;
		logic [1:0]         reg_idx;
		logic [CFG_W-1:0]   value;
		request_t           rq;
		bit                 typed;
		pixel_result_t      want;
	} row_t;

	typedef struct {
		logic [CFG_W-1:0] sw;
		logic [CFG_W-1:0] sh;
		logic [CFG_W-1:0] tw;
		logic [CFG_W-1:0] th;
		int               items;
		idle_mode_t       mode;
	} size_phase_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = nns_pkg::ACT_LOAD;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// scoreboard copy of the block state
	logic [PIX_W-1:0] pixel_mem [STORE_DEPTH];
	bit               loaded [STORE_DEPTH];
	int               load_pos = 0;
	logic [CFG_W-1:0] size_regs [4] = '{7'd64, 7'd64, 7'd0, 7'd0};

	pixel_result_t pending_pixels [$];
	row_t          rows [$];
	size_phase_t   phases [$];
	int            mismatch_count = 0;
	int            src_idle_pct = 0;
	int            sink_idle_pct = 0;

	nearest_neighbor_scaler_swizzle dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("[nearest_neighbor_scaler_swizzle] ERROR");
		$finish;
	end

	function automatic int clamp_side(int v, bit allow_zero);
		if (!allow_zero && v < 1) return 1;
		if (v > MAX_SIDE) return MAX_SIDE;
		return v;
	endfunction

	// effective source size and output size after saturation
	function automatic void scaled_dims(output int sw, output int sh, output int dw,
			output int dh);
		int tw;
		int th;
		sw = clamp_side(int'(size_regs[nns_pkg::REG_SRC_WIDTH]), 1'b0);
		sh = clamp_side(int'(size_regs[nns_pkg::REG_SRC_HEIGHT]), 1'b0);
		tw = clamp_side(int'(size_regs[nns_pkg::REG_TGT_WIDTH]), 1'b1);
		th = clamp_side(int'(size_regs[nns_pkg::REG_TGT_HEIGHT]), 1'b1);
		if (tw != 0 && th != 0) begin
			dw = tw;
			dh = th;
		end else begin
			dw = sw;
			dh = sh;
		end
	endfunction

	// store index sampled for an output coordinate, -1 when outside the output
	function automatic int source_index(int col, int row);
		int sw;
		int sh;
		int dw;
		int dh;
		scaled_dims(sw, sh, dw, dh);
		if (col >= dw || row >= dh) return -1;
		return (row * sh / dh) * sw + col * sw / dw;
	endfunction

	// updates the scoreboard for one accepted request, returns 1 for a result
	function automatic bit scale_request(input request_t rq, output pixel_result_t res);
		int sw;
		int sh;
		int dw;
		int dh;
		int idx;
		logic [PIX_W-1:0] word;
		res = '0;
		scaled_dims(sw, sh, dw, dh);
		if (rq.action == nns_pkg::ACT_LOAD) begin
			if (load_pos >= sw * sh) load_pos = 0;
			pixel_mem[load_pos] = {rq.alpha, rq.blue, rq.green, rq.red};
			loaded[load_pos] = 1'b1;
			load_pos++;
			if (load_pos >= sw * sh) load_pos = 0;
			return 1'b0;
		end
		idx = source_index(int'(rq.col), int'(rq.row));
		if (idx < 0) begin
			res.oor = 1'b1;
		end else begin
			word = pixel_mem[idx];
			res.red   = word[7:0];
			res.green = word[15:8];
			res.blue  = word[23:16];
			res.alpha = word[31:24];
		end
		return 1'b1;
	endfunction

	function automatic void check_field(string name, logic [CHAN_W-1:0] want,
			logic [CHAN_W-1:0] got);
		if (got !== want) begin
			mismatch_count++;
			// cap the log on a badly broken design
			if (mismatch_count <= PRINT_MAX)
				$display("%0t: %s expected %h, actual %h", $time, name, want, got);
		end
	endfunction

	function automatic void add_row(input row_t r);
		rows.insert(rows.size(), r);
	endfunction

	function automatic void add_phase(input size_phase_t ph);
		phases.insert(phases.size(), ph);
	endfunction

	task automatic send_request(input request_t rq, input bit typed,
			input pixel_result_t typed_res);
		pixel_result_t res;
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= rq.action;
		s_tdata  <= {4'b0, rq.row, rq.col, rq.alpha, rq.blue, rq.green, rq.red};
		do @(posedge clk); while (!s_tready);
		if (scale_request(rq, res))
			pending_pixels.insert(pending_pixels.size(), typed ? typed_res : res);
	endtask

	// loads may still be in flight once the last result is back
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write followed by a read back
	task automatic write_size_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		logic [APB_DATA_W-1:0] rd;
		for (int pass = 0; pass < 2; pass++) begin
			@(negedge clk);
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= (pass == 0);
			paddr   <= {idx, 2'b00};
			pwdata  <= APB_DATA_W'(val);
			@(negedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			rd = prdata;
			@(negedge clk);
			psel    <= 1'b0;
			penable <= 1'b0;
			if (pass == 0) begin
				size_regs[idx] = val;
			end else if (rd !== APB_DATA_W'(val)) begin
				mismatch_count++;
				$display("%0t: register %0d expected %h, actual %h", $time, idx,
					APB_DATA_W'(val), rd);
			end
		end
	endtask

	function automatic row_t cfg_row(logic [1:0] idx, logic [CFG_W-1:0] val);
		row_t r;
		r.kind    = ROW_CFG;
		r.reg_idx = idx;
		r.value   = val;
		r.rq      = '0;
		r.typed   = 1'b0;
		r.want    = '0;
		return r;
	endfunction

	function automatic row_t load_row(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
			logic [7:0] alpha);
		row_t r;
		r.kind    = ROW_REQ;
		r.reg_idx = nns_pkg::REG_SRC_WIDTH;
		r.value   = '0;
		r.rq      = '{nns_pkg::ACT_LOAD, red, green, blue, alpha, 6'd0, 6'd0};
		r.typed   = 1'b0;
		r.want    = '0;
		return r;
	endfunction

	function automatic row_t fetch_row(logic [5:0] col, logic [5:0] row, bit typed,
			logic [7:0] blue, logic [7:0] green, logic [7:0] red, logic [7:0] alpha,
			logic oor);
		row_t r;
		r.kind    = ROW_REQ;
		r.reg_idx = nns_pkg::REG_SRC_WIDTH;
		r.value   = '0;
		r.rq      = '{nns_pkg::ACT_FETCH, 8'd0, 8'd0, 8'd0, 8'd0, col, row};
		r.typed   = typed;
		r.want    = '{blue, green, red, alpha, oor};
		return r;
	endfunction

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		pixel_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				mismatch_count++;
				$display("%0t: result expected none, actual %h/%b", $time, m_tdata, m_tuser);
			end else begin
				want = pending_pixels.pop_front();
				check_field("blue", want.blue, m_tdata[7:0]);
				check_field("green", want.green, m_tdata[15:8]);
				check_field("red", want.red, m_tdata[23:16]);
				check_field("alpha", want.alpha, m_tdata[31:24]);
				check_field("out_of_range", {7'd0, want.oor}, {7'd0, m_tuser});
			end
		end
	end

	initial begin
		request_t      rq;
		pixel_result_t blank;
		int            sw;
		int            sh;
		int            dw;
		int            dh;
		int            idx;
		bit            found;

		blank = '0;
		// 2x2 image, then upscale, saturated targets and a shrunken source
		add_row(cfg_row(nns_pkg::REG_SRC_WIDTH, 7'd2));
		add_row(cfg_row(nns_pkg::REG_SRC_HEIGHT, 7'd2));
		add_row(load_row(8'h00, 8'h00, 8'h00, 8'h00));
		add_row(load_row(8'hFF, 8'hFF, 8'hFF, 8'hFF));
		add_row(load_row(8'h12, 8'h34, 8'h56, 8'h78));
		add_row(load_row(8'hA5, 8'h5A, 8'hC3, 8'h3C));
		add_row(fetch_row(6'd0, 6'd0, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
		add_row(fetch_row(6'd1, 6'd0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
		add_row(fetch_row(6'd0, 6'd1, 1'b1, 8'h56, 8'h34, 8'h12, 8'h78, 1'b0));
		add_row(fetch_row(6'd1, 6'd1, 1'b1, 8'hC3, 8'h5A, 8'hA5, 8'h3C, 1'b0));
		add_row(fetch_row(6'd2, 6'd0, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
		add_row(fetch_row(6'd63, 6'd63, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
		add_row(cfg_row(nns_pkg::REG_TGT_WIDTH, 7'd4));
		add_row(cfg_row(nns_pkg::REG_TGT_HEIGHT, 7'd4));
		add_row(fetch_row(6'd3, 6'd3, 1'b1, 8'hC3, 8'h5A, 8'hA5, 8'h3C, 1'b0));
		add_row(fetch_row(6'd0, 6'd4, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
		// one zero target dimension keeps the source size
		add_row(cfg_row(nns_pkg::REG_TGT_HEIGHT, 7'd0));
		add_row(fetch_row(6'd3, 6'd0, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
		add_row(cfg_row(nns_pkg::REG_TGT_WIDTH, 7'd127));
		add_row(cfg_row(nns_pkg::REG_TGT_HEIGHT, 7'd127));
		add_row(fetch_row(6'd63, 6'd63, 1'b1, 8'hC3, 8'h5A, 8'hA5, 8'h3C, 1'b0));
		add_row(fetch_row(6'd63, 6'd0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
		add_row(load_row(8'h01, 8'h02, 8'h04, 8'h08));
		add_row(load_row(8'h10, 8'h20, 8'h40, 8'h80));
		add_row(load_row(8'h7F, 8'hBF, 8'hDF, 8'hEF));
		// zero source width saturates to one, write position goes stale
		add_row(cfg_row(nns_pkg::REG_SRC_WIDTH, 7'd0));
		add_row(load_row(8'hFE, 8'hFD, 8'hFB, 8'hF7));
		add_row(fetch_row(6'd0, 6'd0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
		add_row(fetch_row(6'd63, 6'd63, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));

		add_phase(size_phase_t'{7'd8, 7'd8, 7'd0, 7'd0, 100, SLOW_SINK});
		add_phase(size_phase_t'{7'd5, 7'd3, 7'd13, 7'd7, 100, SLOW_SINK});
		add_phase(size_phase_t'{7'd64, 7'd64, 7'd0, 7'd0, 150, SLOW_SINK});
		add_phase(size_phase_t'{7'd1, 7'd1, 7'd64, 7'd64, 60, SLOW_SRC});
		add_phase(size_phase_t'{7'd16, 7'd9, 7'd3, 7'd2, 100, SLOW_SRC});
		add_phase(size_phase_t'{7'd127, 7'd2, 7'd64, 7'd1, 100, SLOW_SRC});
		add_phase(size_phase_t'{7'd7, 7'd11, 7'd100, 7'd0, 100, NO_IDLE});
		add_phase(size_phase_t'{7'd40, 7'd33, 7'd64, 7'd64, 150, NO_IDLE});
		add_phase(size_phase_t'{7'd0, 7'd127, 7'd1, 7'd1, 100, NO_IDLE});

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		src_idle_pct  = 20;
		sink_idle_pct = 74;
		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG) begin
				wait_idle();
				write_size_reg(rows[i].reg_idx, rows[i].value);
			end else begin
				send_request(rows[i].rq, rows[i].typed, rows[i].want);
			end
		end

		foreach (phases[p]) begin
			wait_idle();
			write_size_reg(nns_pkg::REG_SRC_WIDTH, phases[p].sw);
			write_size_reg(nns_pkg::REG_SRC_HEIGHT, phases[p].sh);
			write_size_reg(nns_pkg::REG_TGT_WIDTH, phases[p].tw);
			write_size_reg(nns_pkg::REG_TGT_HEIGHT, phases[p].th);
			case (phases[p].mode)
				SLOW_SINK: begin
					src_idle_pct  = 20;
					sink_idle_pct = 74;
				end
				SLOW_SRC: begin
					src_idle_pct  = 74;
					sink_idle_pct = 20;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			scaled_dims(sw, sh, dw, dh);

			// load an image first so that most fetches find written pixels
			for (int n = 0; n < ((sw * sh < BURST_MAX) ? sw * sh : BURST_MAX); n++) begin
				rq = '0;
				rq.action = nns_pkg::ACT_LOAD;
				{rq.red, rq.green, rq.blue, rq.alpha} = $urandom();
				{rq.col, rq.row} = 12'($urandom_range(4095));
				send_request(rq, 1'b0, blank);
			end

			for (int n = 0; n < phases[p].items; n++) begin
				{rq.red, rq.green, rq.blue, rq.alpha} = $urandom();
				{rq.col, rq.row} = 12'($urandom_range(4095));
				rq.action = nns_pkg::ACT_FETCH;
				found = 1'b0;
				if ($urandom_range(99) < 60) begin
					for (int t = 0; t < 16 && !found; t++) begin
						if ($urandom_range(4) != 0) begin
							rq.col = COORD_W'($urandom_range(dw - 1));
							rq.row = COORD_W'($urandom_range(dh - 1));
						end else begin
							rq.col = COORD_W'($urandom_range(63));
							rq.row = COORD_W'($urandom_range(63));
						end
						idx = source_index(int'(rq.col), int'(rq.row));
						found = (idx < 0) || loaded[idx];
					end
				end
				// never read an entry that was not loaded
				if (!found) rq.action = nns_pkg::ACT_LOAD;
				send_request(rq, 1'b0, blank);
			end
		end

		wait_idle();
		if (mismatch_count == 0) begin
			$display("[nearest_neighbor_scaler_swizzle] OK");
		end else begin
			$display("[nearest_neighbor_scaler_swizzle] ERROR");
		end
		$finish;
	end

endmodule
